// ----- sv/smpq_pkg.sv -----
// Shared types and codes for the sorted min priority queue.
// Used by smpq_cell and sorted_min_priority_queue_unit; no dependencies.
package smpq_pkg;

	typedef logic signed [31:0] data_t;
	typedef logic [1:0] func_t;
	typedef logic [1:0] status_t;

	localparam func_t OP_INSERT = 2'd0;
	localparam func_t OP_REMOVE = 2'd1;
	localparam func_t OP_PEEK   = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam data_t EMPTY_VALUE = -32'sd1;
	localparam int    OCC_W       = 7;

	// Broadcast from the control to every cell of the row.
	typedef struct packed {
		logic  ins_en;
		logic  rem_en;
		data_t value;
	} cell_ctl_t;

endpackage

// ----- sv/smpq_cell.sv -----
// One slot of the sorted row: holds one entry, trades it with its neighbors.
// Depends on smpq_pkg.
module smpq_cell (
	input  logic                 clk,
	input  smpq_pkg::cell_ctl_t  ctl,
	input  logic                 live,
	input  logic                 left_take,
	input  smpq_pkg::data_t      left_data,
	input  smpq_pkg::data_t      right_data,
	output logic                 take,
	output smpq_pkg::data_t      data_q
);
	import smpq_pkg::*;

	// New value belongs at or before this slot: slot is empty or holds a larger entry.
	assign take = !live || (ctl.value < data_q);

	always_ff @(posedge clk) begin
		if (ctl.ins_en && take) begin
			// first taking slot gets the new value, the rest shift up by one
			data_q <= left_take ? left_data : ctl.value;
		end else if (ctl.rem_en) begin
			data_q <= right_data;
		end
	end

endmodule

// ----- sv/sorted_min_priority_queue_unit.sv -----
// Top level of the sorted min priority queue: a row of smpq_cell slots,
// entry count and the result register. Depends on smpq_pkg and smpq_cell.
//
//  channel | ports                       | handshake
//  --------+-----------------------------+--------------------------------
//  command | func, value_in              | start & !busy
//  result  | value_out, status, occupancy| done, one cycle, no backpressure
//
// One command per clock: every slot compares against the broadcast value in
// parallel and shifts one step, so busy stays low.
// The result of a command is on the result ports in the cycle after it is taken.
// Reset clears the entry count and done; slot contents stay undefined until written.
// The receiver cannot stall; done is never held.
module sorted_min_priority_queue_unit #(
	parameter int DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  smpq_pkg::func_t      func,
	input  smpq_pkg::data_t      value_in,
	output logic                 done,
	output smpq_pkg::data_t      value_out,
	output smpq_pkg::status_t    status,
	output logic [6:0]           occupancy
);
	import smpq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;
	logic             accept;
	logic             is_full;
	logic             is_empty;
	cell_ctl_t        ctl;
	logic [DEPTH-1:0] live;
	logic [DEPTH-1:0] take;
	data_t            slot   [DEPTH];
	data_t            value_d;
	status_t          status_d;
	data_t            value_out_q;
	status_t          status_q;
	logic             done_q;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	assign ctl.ins_en = accept && (func == OP_INSERT) && !is_full;
	assign ctl.rem_en = accept && (func == OP_REMOVE) && !is_empty;
	assign ctl.value  = value_in;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			assign live[gi] = (CW'(gi) < count_q);
			smpq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.live       (live[gi]),
				.left_take  ((gi == 0) ? 1'b0 : take[(gi == 0) ? 0 : gi - 1]),
				.left_data  (slot[(gi == 0) ? 0 : gi - 1]),
				.right_data (slot[(gi == DEPTH - 1) ? gi : gi + 1]),
				.take       (take[gi]),
				.data_q     (slot[gi])
			);
		end
	endgenerate

	always_comb begin
		count_d  = count_q;
		value_d  = '0;
		status_d = ST_OK;
		case (func)
			OP_INSERT: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			OP_REMOVE, OP_PEEK: begin
				if (is_empty) begin
					value_d  = EMPTY_VALUE;
					status_d = ST_EMPTY;
				end else begin
					value_d = slot[0];
					if (func == OP_REMOVE) begin
						count_d = count_q - CW'(1);
					end
				end
			end
			default: begin
				// unused code: hold the entry count, return zero with OK status
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_out_q <= value_d;
			status_q    <= status_d;
		end
	end

	assign done      = done_q;
	assign value_out = value_out_q;
	assign status    = status_q;
	assign occupancy = OCC_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted beat gave no result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_FULL) |-> count_q == CW'(DEPTH))
		else $error("full status with free slots");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_EMPTY) |-> (count_q == '0) && (value_out == EMPTY_VALUE))
		else $error("empty status inconsistent");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rem_en |=> count_q == $past(count_q) - CW'(1))
		else $error("remove did not drop one entry");

endmodule
